@@ rtl/core/nps_pkg.sv @@
package nps_pkg;

  localparam int MAX_PROBES = 64;
  localparam int COORD_BITS = 24;

  // Index of a stored entry, and a count that can also hold MAX_PROBES itself
  localparam int IDX_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam int CNT_W = $clog2(MAX_PROBES + 1);

  // Index fields of the result are fixed at 6 bits
  localparam int OUT_IDX_W = 6;

  // Squared distance: each |d| fits COORD_BITS, three squares add two bits
  localparam int MAG_W  = COORD_BITS;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int DIST_W = SQ_W + 2;

  // RAM read plus three distance stages
  localparam int PIPE_DEPTH = 4;

  typedef enum logic [1:0] {
    CMD_ADD_LIGHT = 2'd0,
    CMD_ADD_REFL  = 2'd1,
    CMD_QUERY     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_ADDED   = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_ANSWER  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SRC_NEAREST  = 2'd0,
    SRC_FALLBACK = 2'd1,
    SRC_NONE     = 2'd2
  } src_e;

  typedef enum logic [1:0] {
    MODE_NEAREST  = 2'd0,
    MODE_DISABLED = 2'd1,
    MODE_OTHER    = 2'd2
  } blend_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } pos_t;

  localparam int POS_W = $bits(pos_t);

  // Travels alongside a read through the RAM and distance pipeline
  typedef struct packed {
    logic             vl;
    logic             vr;
    logic [IDX_W-1:0] idx;
  } tag_t;

endpackage

@@ rtl/core/nps_ram.sv @@
module nps_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 72
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/core/nps_dist.sv @@
module nps_dist (
  input  logic                         clk_i,
  input  nps_pkg::pos_t                p_i,
  input  nps_pkg::pos_t                q_i,
  output logic [nps_pkg::DIST_W-1:0]   dist_o
);
  import nps_pkg::*;

  logic signed [COORD_BITS:0] dx, dy, dz;
  logic [MAG_W-1:0]           ax_d, ay_d, az_d;
  logic [MAG_W-1:0]           ax_q, ay_q, az_q;
  logic [SQ_W-1:0]            sx_q, sy_q, sz_q;
  logic [DIST_W-1:0]          sum_d;

  // Stage 1: per-axis difference and magnitude
  always_comb begin
    dx = {p_i.x[COORD_BITS-1], p_i.x} - {q_i.x[COORD_BITS-1], q_i.x};
    dy = {p_i.y[COORD_BITS-1], p_i.y} - {q_i.y[COORD_BITS-1], q_i.y};
    dz = {p_i.z[COORD_BITS-1], p_i.z} - {q_i.z[COORD_BITS-1], q_i.z};
    ax_d = dx[COORD_BITS] ? MAG_W'(-dx) : MAG_W'(dx);
    ay_d = dy[COORD_BITS] ? MAG_W'(-dy) : MAG_W'(dy);
    az_d = dz[COORD_BITS] ? MAG_W'(-dz) : MAG_W'(dz);
  end

  assign sum_d = DIST_W'(sx_q) + DIST_W'(sy_q) + DIST_W'(sz_q);

  always_ff @(posedge clk_i) begin
    ax_q   <= ax_d;
    ay_q   <= ay_d;
    az_q   <= az_d;
    // Stage 2: one square per axis
    sx_q   <= SQ_W'(ax_q) * SQ_W'(ax_q);
    sy_q   <= SQ_W'(ay_q) * SQ_W'(ay_q);
    sz_q   <= SQ_W'(az_q) * SQ_W'(az_q);
    // Stage 3: sum
    dist_o <= sum_d;
  end

endmodule

@@ rtl/core/nps_best.sv @@
module nps_best (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        valid_i,
  input  logic [nps_pkg::IDX_W-1:0]   idx_i,
  input  logic [nps_pkg::DIST_W-1:0]  dist_i,
  output logic [nps_pkg::IDX_W-1:0]   idx_o
);
  import nps_pkg::*;

  logic              has_q, has_d;
  logic [IDX_W-1:0]  best_q, best_d;
  logic [DIST_W-1:0] bd_q, bd_d;
  logic              take;

  // Strict compare keeps the lowest index on ties
  assign take = valid_i && (!has_q || (dist_i < bd_q));

  always_comb begin
    has_d  = has_q;
    best_d = best_q;
    bd_d   = bd_q;
    if (clear_i) begin
      has_d = 1'b0;
    end else if (take) begin
      has_d  = 1'b1;
      best_d = idx_i;
      bd_d   = dist_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_q <= 1'b0;
    end else begin
      has_q <= has_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    bd_q   <= bd_d;
  end

  assign idx_o = best_q;

endmodule

@@ rtl/core/nearest_probe_search.sv @@
// Nearest probe search over two tables of 3D probe positions (light and
// reflection), signed Q16.8, up to MAX_PROBES entries each. An add item
// appends its position to one table and answers "added", or "full" if the
// table already holds MAX_PROBES entries. A query item scans both tables
// together, one entry of each per cycle, through a four-deep pipeline (RAM
// read, axis magnitudes, squares, sum) and keeps the entry with the least
// squared distance, lowest index on ties. A query in nearest mode passes
// the scan, drain and done states before its result is registered; in the
// other modes or with both tables empty it goes straight to done. The scan
// runs to the larger fill count; each table RAM has a single read port.
// The tables need no clearing after reset: only entries below the fill
// count are used. Write blend_mode only while the block is idle.
module nearest_probe_search (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  // Configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          blend_mode_i,

  // Input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic signed [nps_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic signed [nps_pkg::COORD_BITS-1:0] pos_y_i,
  input  logic signed [nps_pkg::COORD_BITS-1:0] pos_z_i,

  // Result items
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [1:0]                          light_source_o,
  output logic [5:0]                          light_index_o,
  output logic [1:0]                          refl_source_o,
  output logic [5:0]                          refl_index_o
);
  import nps_pkg::*;

  state_e state_q, state_d;

  logic [1:0]       blend_q;
  logic [CNT_W-1:0] lc_q, lc_d, rc_q, rc_d;
  logic [CNT_W-1:0] i_q, i_d, n_max;
  pos_t             qpos_q, in_pos;
  tag_t             tag_q [PIPE_DEPTH];
  tag_t             tag_d [PIPE_DEPTH];
  logic             pipe_busy;

  logic             accept, slot_free, is_query, is_add_l, is_add_r;
  logic             full_l, full_r, scan_needed, last_issue;
  logic             issue, load_add, load_query;
  logic             we_l, we_r;

  pos_t              rd_l, rd_r;
  logic [DIST_W-1:0] dist_l, dist_r;
  logic [IDX_W-1:0]  best_l, best_r;

  logic [1:0]           lsrc, rsrc;
  logic                 out_valid_q;
  logic [1:0]           status_q, lsrc_q, rsrc_q;
  logic [OUT_IDX_W-1:0] lidx_q, ridx_q;

  // ------------------------------------------------------------------
  // Configuration: single register, always ready
  // ------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q <= MODE_NEAREST;
    end else if (cfg_valid_i) begin
      blend_q <= blend_mode_i;
    end
  end

  // ------------------------------------------------------------------
  // Input decode
  // ------------------------------------------------------------------
  assign in_pos   = '{x: pos_x_i, y: pos_y_i, z: pos_z_i};
  assign accept   = in_valid_i && !in_stall_o;
  assign is_query = (command_i == CMD_QUERY);
  assign is_add_l = (command_i == CMD_ADD_LIGHT);
  assign is_add_r = (command_i == CMD_ADD_REFL);
  assign full_l   = (lc_q == CNT_W'(MAX_PROBES));
  assign full_r   = (rc_q == CNT_W'(MAX_PROBES));

  // The output register can take a result this cycle
  assign slot_free = !out_valid_q || !out_stall_i;

  assign n_max       = (lc_q > rc_q) ? lc_q : rc_q;
  assign scan_needed = (blend_q == MODE_NEAREST) && (n_max != '0);
  assign last_issue  = (i_q == n_max - CNT_W'(1));

  // Anything still travelling down the read/distance pipeline
  always_comb begin
    pipe_busy = 1'b0;
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      pipe_busy = pipe_busy | tag_q[k].vl | tag_q[k].vr;
    end
  end

  // ------------------------------------------------------------------
  // Sequencer: next state
  // ------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_d = scan_needed ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Sequencer: outputs
  // ------------------------------------------------------------------
  always_comb begin
    in_stall_o = 1'b1;
    issue      = 1'b0;
    load_query = 1'b0;
    case (state_q)
      ST_IDLE:  in_stall_o = !slot_free;
      ST_SCAN:  issue      = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  load_query = slot_free;
      default:  in_stall_o = 1'b1;
    endcase
  end

  // Adds finish in the accept cycle; unknown commands are dropped silently
  assign load_add = accept && (is_add_l || is_add_r);
  assign we_l     = accept && is_add_l && !full_l;
  assign we_r     = accept && is_add_r && !full_r;

  // ------------------------------------------------------------------
  // Fill counts, scan counter, query point
  // ------------------------------------------------------------------
  always_comb begin
    lc_d = lc_q;
    rc_d = rc_q;
    i_d  = i_q;
    if (we_l) begin
      lc_d = lc_q + CNT_W'(1);
    end
    if (we_r) begin
      rc_d = rc_q + CNT_W'(1);
    end
    if (accept) begin
      i_d = '0;
    end else if (issue) begin
      i_d = i_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lc_q    <= '0;
      rc_q    <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      lc_q    <= lc_d;
      rc_q    <= rc_d;
      i_q     <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_query) begin
      qpos_q <= in_pos;
    end
  end

  // ------------------------------------------------------------------
  // Tables. Writes happen only in the idle cycle of an add and read data is
  // used only during a scan, so a read never meets a write to the same entry.
  // ------------------------------------------------------------------
  nps_ram #(
    .DEPTH (MAX_PROBES),
    .WIDTH (POS_W)
  ) u_light_ram (
    .clk_i   (clk_i),
    .we_i    (we_l),
    .waddr_i (lc_q[IDX_W-1:0]),
    .wdata_i (in_pos),
    .raddr_i (i_q[IDX_W-1:0]),
    .rdata_o (rd_l)
  );

  nps_ram #(
    .DEPTH (MAX_PROBES),
    .WIDTH (POS_W)
  ) u_refl_ram (
    .clk_i   (clk_i),
    .we_i    (we_r),
    .waddr_i (rc_q[IDX_W-1:0]),
    .wdata_i (in_pos),
    .raddr_i (i_q[IDX_W-1:0]),
    .rdata_o (rd_r)
  );

  // ------------------------------------------------------------------
  // Tag pipeline: mark which table holds a live entry at each read
  // ------------------------------------------------------------------
  always_comb begin
    tag_d[0].vl  = issue && (i_q < lc_q);
    tag_d[0].vr  = issue && (i_q < rc_q);
    tag_d[0].idx = i_q[IDX_W-1:0];
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      tag_d[k] = tag_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        tag_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        tag_q[k] <= tag_d[k];
      end
    end
  end

  // ------------------------------------------------------------------
  // Distance units and running minimum, one per table
  // ------------------------------------------------------------------
  nps_dist u_light_dist (
    .clk_i  (clk_i),
    .p_i    (rd_l),
    .q_i    (qpos_q),
    .dist_o (dist_l)
  );

  nps_dist u_refl_dist (
    .clk_i  (clk_i),
    .p_i    (rd_r),
    .q_i    (qpos_q),
    .dist_o (dist_r)
  );

  nps_best u_light_best (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (accept),
    .valid_i (tag_q[PIPE_DEPTH-1].vl),
    .idx_i   (tag_q[PIPE_DEPTH-1].idx),
    .dist_i  (dist_l),
    .idx_o   (best_l)
  );

  nps_best u_refl_best (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (accept),
    .valid_i (tag_q[PIPE_DEPTH-1].vr),
    .idx_i   (tag_q[PIPE_DEPTH-1].idx),
    .dist_i  (dist_r),
    .idx_o   (best_r)
  );

  // ------------------------------------------------------------------
  // Query answer: an empty table or disabled mode falls back; modes 2 and 3 bind nothing
  // ------------------------------------------------------------------
  always_comb begin
    case (blend_q)
      MODE_NEAREST: begin
        lsrc = (lc_q == '0) ? SRC_FALLBACK : SRC_NEAREST;
        rsrc = (rc_q == '0) ? SRC_FALLBACK : SRC_NEAREST;
      end
      MODE_DISABLED: begin
        lsrc = SRC_FALLBACK;
        rsrc = SRC_FALLBACK;
      end
      default: begin
        lsrc = SRC_NONE;
        rsrc = SRC_NONE;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // Output register: hold the result until taken
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_add || load_query) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_add) begin
      status_q <= (is_add_l ? full_l : full_r) ? STAT_FULL : STAT_ADDED;
      lsrc_q   <= SRC_NONE;
      lidx_q   <= '0;
      rsrc_q   <= SRC_NONE;
      ridx_q   <= '0;
    end else if (load_query) begin
      status_q <= STAT_ANSWER;
      lsrc_q   <= lsrc;
      lidx_q   <= (lsrc == SRC_NEAREST) ? OUT_IDX_W'(best_l) : '0;
      rsrc_q   <= rsrc;
      ridx_q   <= (rsrc == SRC_NEAREST) ? OUT_IDX_W'(best_r) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign light_source_o = lsrc_q;
  assign light_index_o  = lidx_q;
  assign refl_source_o  = rsrc_q;
  assign refl_index_o   = ridx_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_add || load_query) |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over an unread result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lc_q <= CNT_W'(MAX_PROBES)) && (rc_q <= CNT_W'(MAX_PROBES)))
    else $error("table fill count beyond capacity");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (i_q < n_max))
    else $error("scan address beyond filled entries");

  a_done_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !pipe_busy)
    else $error("answer taken while distances still in flight");

endmodule
